FILE: rtl/core/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // field widths
  localparam int RANK_W    = 16;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 7;

  // item modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // request beat
  typedef struct packed {
    logic                 mode;
    logic [RANK_W-1:0]    item_rank;
    logic [PAYLOAD_W-1:0] item_payload;
  } spq_req_t;

  // response beat
  typedef struct packed {
    logic [RANK_W-1:0]    out_rank;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [STATUS_W-1:0]  status;
    logic [OCC_W-1:0]     occupancy;
    logic                 is_empty;
  } spq_rsp_t;

  // one stored entry
  typedef struct packed {
    logic [RANK_W-1:0]    rank;
    logic [PAYLOAD_W-1:0] payload;
  } spq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic [RANK_W-1:0]    rank;
    logic [PAYLOAD_W-1:0] payload;
  } spq_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
// Sorted priority queue of up to DEPTH entries, kept in ascending rank order.
// Request channel (req_valid, req_stall, req): mode selects insert or remove;
// an insert carries item_rank and item_payload. Among equal ranks the newest
// entry leaves first. A beat is taken when req_valid is high and req_stall low.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one beat per request,
// with the removed rank and payload (zero on insert, overflow or underflow),
// a status code, the occupancy after the item and an empty flag.
// The response beat appears in the cycle after the request beat. Throughput is one
// item per cycle while req_stall is low: the store is a row of DEPTH cells that all
// compare the new rank in parallel and shift one slot left or right together.
// The response register holds the result while rsp_stall is high; req_stall
// follows it, so no new item is taken until the pending response leaves.
// Reset (synchronous, rst high) empties the queue and drops any pending
// response; stored ranks and payloads are not cleared.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire spq_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output spq_rsp_t      rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic           accept;
  logic           full;
  logic           empty;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  spq_cmd_t       cmd;
  spq_rsp_t       rsp_next;

  logic       occ         [DEPTH];
  logic       ge          [DEPTH];
  logic       left_ge     [DEPTH];
  spq_entry_t entry       [DEPTH];
  spq_entry_t left_entry  [DEPTH];
  spq_entry_t right_entry [DEPTH];

  // handshake
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // command to the cells, gated by overflow and underflow
  always_comb begin
    cmd.ins     = accept && (req.mode == MODE_INSERT) && !full;
    cmd.rem     = accept && (req.mode == MODE_REMOVE) && !empty;
    cmd.rank    = req.item_rank;
    cmd.payload = req.item_payload;
  end

  // cell row with neighbor links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (count > CW'(i));

    if (i == 0) begin : g_first
      assign left_ge[i]    = 1'b0;
      assign left_entry[i] = '0;
    end else begin : g_mid
      assign left_ge[i]    = ge[i-1];
      assign left_entry[i] = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry[i] = entry[i];
    end else begin : g_inner
      assign right_entry[i] = entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ[i]),
      .left_ge     (left_ge[i]),
      .left_entry  (left_entry[i]),
      .right_entry (right_entry[i]),
      .ge          (ge[i]),
      .entry       (entry[i])
    );
  end

  // count update and response contents
  always_comb begin
    count_next           = count;
    rsp_next.out_rank    = '0;
    rsp_next.out_payload = '0;
    rsp_next.status      = ST_OK;
    if (req.mode == MODE_INSERT) begin
      if (full) begin
        rsp_next.status = ST_OVERFLOW;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (empty) begin
        rsp_next.status = ST_UNDERFLOW;
      end else begin
        count_next           = count - CW'(1);
        rsp_next.out_rank    = entry[0].rank;
        rsp_next.out_payload = entry[0].payload;
      end
    end
    rsp_next.occupancy = OCC_W'(count_next);
    rsp_next.is_empty  = (count_next == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response beat register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  // a pending response agrees with the current fill level
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  // insert into a full queue reports overflow with zero data
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_INSERT && full) |=>
      (rsp_valid && rsp.status == ST_OVERFLOW && rsp.out_payload == '0))
    else $error("missing overflow report");

  // remove from an empty queue reports underflow with zero data
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_REMOVE && empty) |=>
      (rsp_valid && rsp.status == ST_UNDERFLOW && rsp.out_rank == '0 && count == '0))
    else $error("missing underflow report");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/spq_cell.sv
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire spq_cmd_t   cmd,
  input  wire logic       occ,
  input  wire logic       left_ge,
  input  wire spq_entry_t left_entry,
  input  wire spq_entry_t right_entry,
  output logic            ge,
  output spq_entry_t      entry
);

  spq_entry_t entry_next;

  // new rank goes at or before this slot (empty slots always qualify)
  assign ge = !occ || (entry.rank >= cmd.rank);

  // insert shifts right from the slot, remove shifts everything left
  always_comb begin
    entry_next = entry;
    if (cmd.ins) begin
      if (left_ge) begin
        entry_next = left_entry;
      end else if (ge) begin
        entry_next.rank    = cmd.rank;
        entry_next.payload = cmd.payload;
      end
    end else if (cmd.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire
